// ===== sv/tpsa_pkg.sv =====
package tpsa_pkg;

   localparam int WordBits   = 32;
   localparam int Parties    = 3;
   localparam int CarrySteps = 31;
   localparam int ChunkSteps = 8;
   localparam int Chunks     = (CarrySteps + ChunkSteps - 1) / ChunkSteps;

   typedef logic [WordBits-1:0] word_type;

   typedef enum logic {
      OP_AND = 1'b0,
      OP_ADD = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      word_type [Parties-1:0]  x;
      word_type [Parties-1:0]  y;
      word_type [Parties-1:0]  r;
      word_type [Parties-1:0]  c;
   } stage_type;

   // Runs one chunk of the shared ripple carry; chunk k covers bit steps
   // k*ChunkSteps to k*ChunkSteps+ChunkSteps-1, skipping any at or above CarrySteps.
   function automatic stage_type carry_chunk(stage_type s, int k);
      stage_type           o;
      logic [Parties-1:0]  a;
      logic [Parties-1:0]  b;
      logic [Parties-1:0]  nb;
      int                  i;
      int                  q;
      o = s;
      for (int j = 0; j < ChunkSteps; j++) begin
         i = k * ChunkSteps + j;
         if (i < CarrySteps) begin
            for (int p = 0; p < Parties; p++) begin
               a[p] = o.x[p][i] ^ o.c[p][i];
               b[p] = o.y[p][i] ^ o.c[p][i];
            end
            for (int p = 0; p < Parties; p++) begin
               q = (p + 1) % Parties;
               nb[p] = (a[p] & b[q]) ^ (a[q] & b[p]) ^ (a[p] & b[p])
                     ^ o.r[q][i] ^ o.c[p][i] ^ o.r[p][i];
            end
            for (int p = 0; p < Parties; p++) begin
               o.c[p][i+1] = nb[p];
            end
         end
      end
      return o;
   endfunction

   function automatic word_type shared_and(stage_type s, int p);
      int q;
      q = (p + 1) % Parties;
      return (s.x[p] & s.y[q]) ^ (s.x[q] & s.y[p]) ^ (s.x[p] & s.y[p])
           ^ s.r[p] ^ s.r[q];
   endfunction

endpackage

// ===== sv/tpsa_if.sv =====
interface tpsa_req_if import tpsa_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     opcode;
   word_type x_share0;
   word_type x_share1;
   word_type x_share2;
   word_type y_share0;
   word_type y_share1;
   word_type y_share2;
   word_type rand0;
   word_type rand1;
   word_type rand2;

   modport source (
      output valid, opcode, x_share0, x_share1, x_share2,
             y_share0, y_share1, y_share2, rand0, rand1, rand2,
      input  ready
   );
   modport sink (
      input  valid, opcode, x_share0, x_share1, x_share2,
             y_share0, y_share1, y_share2, rand0, rand1, rand2,
      output ready
   );
endinterface

interface tpsa_rsp_if import tpsa_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type z_share0;
   word_type z_share1;
   word_type z_share2;
   word_type view_word0;
   word_type view_word1;
   word_type view_word2;

   modport source (
      output valid, z_share0, z_share1, z_share2,
             view_word0, view_word1, view_word2,
      input  ready
   );
   modport sink (
      input  valid, z_share0, z_share1, z_share2,
             view_word0, view_word1, view_word2,
      output ready
   );
endinterface

// ===== sv/three_party_share_and_add_core.sv =====
// Channel   | Dir | Beat contents
// ----------+-----+-------------------------------------------------------
// req_chan  | in  | opcode, x_share0..2, y_share0..2, rand0..2
// rsp_chan  | out | z_share0..2, view_word0..2
//
// One gate per cycle sustained while rsp_chan is not stalled. From accept to rsp valid a gate passes the
// input register, four carry stages of up to 8 bit steps each, and the output register.
// The 31-step shared carry chain sets the depth.
// Synchronous reset clears only the valid bits.
// A stalled rsp beat freezes the whole pipe; req_chan.ready drops with it.
module three_party_share_and_add_core
   import tpsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   tpsa_req_if.sink     req_chan,
   tpsa_rsp_if.source   rsp_chan
);

   localparam int Depth = Chunks + 1;

   stage_type                stg_ff [Depth];
   stage_type                stg_in [Depth];
   logic      [Depth-1:0]    stg_valid_ff;

   word_type  [Parties-1:0]  z_ff,    z_in;
   word_type  [Parties-1:0]  view_ff, view_in;
   logic                     out_valid_ff;
   op_type                   out_op_ff;
   logic                     advance;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      stg_in[0].op   = op_type'(req_chan.opcode);
      stg_in[0].x[0] = req_chan.x_share0;
      stg_in[0].x[1] = req_chan.x_share1;
      stg_in[0].x[2] = req_chan.x_share2;
      stg_in[0].y[0] = req_chan.y_share0;
      stg_in[0].y[1] = req_chan.y_share1;
      stg_in[0].y[2] = req_chan.y_share2;
      stg_in[0].r[0] = req_chan.rand0;
      stg_in[0].r[1] = req_chan.rand1;
      stg_in[0].r[2] = req_chan.rand2;
      stg_in[0].c    = '0;
   end

   for (genvar k = 0; k < Chunks; k++) begin : g_chunk
      always_comb begin
         stg_in[k+1] = carry_chunk(stg_ff[k], k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         stg_valid_ff <= {stg_valid_ff[Depth-2:0], req_chan.valid};
         out_valid_ff <= stg_valid_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < Depth; s++) begin
            stg_ff[s] <= stg_in[s];
         end
         z_ff      <= z_in;
         view_ff   <= view_in;
         out_op_ff <= stg_ff[Depth-1].op;
      end
   end

   always_comb begin
      for (int p = 0; p < Parties; p++) begin
         if (stg_ff[Depth-1].op == OP_ADD) begin
            z_in[p]    = stg_ff[Depth-1].x[p] ^ stg_ff[Depth-1].y[p]
                       ^ stg_ff[Depth-1].c[p];
            view_in[p] = stg_ff[Depth-1].c[p];
         end else begin
            z_in[p]    = shared_and(stg_ff[Depth-1], p);
            view_in[p] = z_in[p];
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.z_share0   = z_ff[0];
   assign rsp_chan.z_share1   = z_ff[1];
   assign rsp_chan.z_share2   = z_ff[2];
   assign rsp_chan.view_word0 = view_ff[0];
   assign rsp_chan.view_word1 = view_ff[1];
   assign rsp_chan.view_word2 = view_ff[2];

   a_and_view: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_op_ff == OP_AND |-> view_ff == z_ff)
      else $error("and beat: view words differ from output shares");

   a_carry_lsb: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_op_ff == OP_ADD |->
         !view_ff[0][0] && !view_ff[1][0] && !view_ff[2][0])
      else $error("add beat: carry bit 0 not zero");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> stg_valid_ff[0])
      else $error("accepted beat missing from first stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      advance && stg_valid_ff[Depth-1] |=> out_valid_ff)
      else $error("last stage beat lost before output register");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stg_valid_ff) && $stable(z_ff) && $stable(view_ff))
      else $error("pipe moved during stall");

endmodule

// ===== tb/gate_share_checker.sv =====
module gate_share_checker
   import tpsa_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   tpsa_req_if   req_mon,
   tpsa_rsp_if   rsp_mon,
   output int    mismatch_count,
   output int    pending_count
);

   // [2:0] output shares, [5:3] view words
   typedef word_type [5:0] gate_words_type;

   localparam int MaxReports = 10;

   string          field_name [6] = '{"z_share0", "z_share1", "z_share2",
                                      "view_word0", "view_word1", "view_word2"};
   gate_words_type predicted_shares [$];
   int             failures = 0;

   function automatic gate_words_type evaluate_gate(op_type op, word_type [2:0] x,
                                                    word_type [2:0] y, word_type [2:0] r);
      word_type [2:0]      z;
      word_type [2:0]      c;
      logic [Parties-1:0]  a;
      logic [Parties-1:0]  b;
      logic [Parties-1:0]  nb;
      int                  q;
      if (op == OP_AND) begin
         for (int p = 0; p < Parties; p++) begin
            q = (p + 1) % Parties;
            z[p] = (x[p] & y[q]) ^ (x[q] & y[p]) ^ (x[p] & y[p]) ^ r[p] ^ r[q];
         end
         return {z, z};
      end
      // shared ripple carry: bit 0 stays clear, nothing leaves bit 31
      c = '0;
      for (int i = 0; i < CarrySteps; i++) begin
         for (int p = 0; p < Parties; p++) begin
            a[p] = x[p][i] ^ c[p][i];
            b[p] = y[p][i] ^ c[p][i];
         end
         for (int p = 0; p < Parties; p++) begin
            q = (p + 1) % Parties;
            nb[p] = (a[p] & b[q]) ^ (a[q] & b[p]) ^ (a[p] & b[p])
                  ^ c[p][i] ^ r[p][i] ^ r[q][i];
         end
         for (int p = 0; p < Parties; p++) begin
            c[p][i+1] = nb[p];
         end
      end
      z = x ^ y ^ c;
      return {c, z};
   endfunction

   always @(posedge clock) begin : watch
      gate_words_type got;
      gate_words_type want;
      if (reset) begin
         predicted_shares.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predicted_shares.push_back(evaluate_gate(
               op_type'(req_mon.opcode),
               {req_mon.x_share2, req_mon.x_share1, req_mon.x_share0},
               {req_mon.y_share2, req_mon.y_share1, req_mon.y_share0},
               {req_mon.rand2, req_mon.rand1, req_mon.rand0}));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.view_word2, rsp_mon.view_word1, rsp_mon.view_word0,
                   rsp_mon.z_share2, rsp_mon.z_share1, rsp_mon.z_share0};
            if (predicted_shares.size() == 0) begin
               if (failures < MaxReports)
                  $display("%0t: result beat with no gate outstanding", $time);
               failures++;
            end else begin
               want = predicted_shares.pop_front();
               for (int k = 0; k < 6; k++) begin
                  if (got[k] !== want[k]) begin
                     if (failures < MaxReports)
                        $display("%0t: %s mismatch: expected %h, got %h",
                                 $time, field_name[k], want[k], got[k]);
                     failures++;
                  end
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_count  <= predicted_shares.size();
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import tpsa_pkg::*;

   localparam int ResetCycles  = 10;
   localparam int RandomItems  = 1830;
   localparam int HoldCycles   = 300;
   localparam int StallLimit   = 4000;
   localparam int SettleCycles = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpsa_req_if req_chan ();
   tpsa_rsp_if rsp_chan ();

   int mismatches;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_trigger  = 0;
   int stall_cycles  = 0;
   int and_count     = 0;
   int add_count     = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   three_party_share_and_add_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   gate_share_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   // XOR-split a word into three random shares
   function automatic word_type [2:0] split_word(word_type value);
      word_type s0;
      word_type s1;
      s0 = $urandom;
      s1 = $urandom;
      return {value ^ s0 ^ s1, s1, s0};
   endfunction

   function automatic word_type [2:0] random_words();
      return {word_type'($urandom), word_type'($urandom), word_type'($urandom)};
   endfunction

   // operand values that stretch the carry chain
   function automatic word_type pick_operand();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 32'h0000_0001;
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_gate(op_type op, word_type [2:0] x, word_type [2:0] y,
                            word_type [2:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.x_share0 <= x[0];
      req_chan.x_share1 <= x[1];
      req_chan.x_share2 <= x[2];
      req_chan.y_share0 <= y[0];
      req_chan.y_share1 <= y[1];
      req_chan.y_share2 <= y[2];
      req_chan.rand0    <= r[0];
      req_chan.rand1    <= r[1];
      req_chan.rand2    <= r[2];
      do @(posedge clock); while (!req_chan.ready);
      if (op == OP_ADD)
         add_count++;
      else
         and_count++;
   endtask

   // response side; a long hold-off is taken each time the stimulus asks
   initial begin : receiver
      int hold_left;
      int holds_taken;
      hold_left   = 0;
      holds_taken = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_taken != hold_trigger) begin
            holds_taken++;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      word_type corner_x [6];
      word_type corner_y [6];
      word_type [2:0] x;
      word_type [2:0] y;
      word_type [2:0] r;
      op_type op;
      corner_x = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff,
                   32'h7fff_ffff, 32'h8000_0000, 32'haaaa_aaaa};
      corner_y = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
                   32'h0000_0001, 32'h8000_0000, 32'h5555_5555};
      req_chan.valid    = 1'b0;
      req_chan.opcode   = OP_AND;
      req_chan.x_share0 = '0;
      req_chan.x_share1 = '0;
      req_chan.x_share2 = '0;
      req_chan.y_share0 = '0;
      req_chan.y_share1 = '0;
      req_chan.y_share2 = '0;
      req_chan.rand0    = '0;
      req_chan.rand1    = '0;
      req_chan.rand2    = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 49;

      // raw share extremes, then operand corners split into shares
      send_gate(OP_AND, '0, '0, '0);
      send_gate(OP_ADD, '0, '0, '0);
      send_gate(OP_AND, '1, '1, '1);
      send_gate(OP_ADD, '1, '1, '1);
      send_gate(OP_AND, random_words(), random_words(), '0);
      send_gate(OP_ADD, random_words(), random_words(), '1);
      for (int k = 0; k < 6; k++) begin
         send_gate(OP_AND, split_word(corner_x[k]), split_word(corner_y[k]),
                   random_words());
         send_gate(OP_ADD, split_word(corner_x[k]), split_word(corner_y[k]),
                   random_words());
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 49;
            end
            1: begin
               send_idle_pct = 49;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_trigger++;
            end
         endcase
         for (int n = 0; n < RandomItems / 3; n++) begin
            op = ($urandom_range(1) != 0) ? OP_ADD : OP_AND;
            if ($urandom_range(3) == 0) begin
               x = split_word(pick_operand());
               y = split_word(pick_operand());
            end else begin
               x = random_words();
               y = random_words();
            end
            case ($urandom_range(15))
               0: r = '0;
               1: r = '1;
               default: r = random_words();
            endcase
            send_gate(op, x, y, r);
         end
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d AND and %0d ADD gates: share and carry corners, random shares",
               and_count, add_count);
      $display("under sender-heavy, receiver-heavy and no idling, plus a %0d-cycle rsp hold",
               HoldCycles);
      if (mismatches == 0 && pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
